// ===== design/timestamped_delay_history_core_defines.svh =====
// assertion macros shared by the timestamped delay history design
// expects signals named clk and rst in the scope of each use
`ifndef TIMESTAMPED_DELAY_HISTORY_CORE_DEFINES_SVH
`define TIMESTAMPED_DELAY_HISTORY_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define TDH_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("tdh same-cycle check failed");

// next-cycle implication, checked outside reset
`define TDH_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("tdh next-cycle check failed");

`endif

// ===== design/tdh_pkg.sv =====
// shared constants, codes and types of the timestamped delay history
// no dependencies
package tdh_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int TIME_W  = 32;
  localparam int POS_W   = 16;
  localparam int GAP_W   = 20;
  localparam int DELAY_W = 20;
  localparam int TYPE_W  = 2;

  localparam logic [GAP_W-1:0] GAP_RESET = GAP_W'(60);

  // request codes; the fourth code is unused
  typedef enum logic [TYPE_W-1:0] {
    REQ_RECORD = 2'd0,
    REQ_QUERY  = 2'd1,
    REQ_CLEAR  = 2'd2
  } req_type_t;

  // what the row of cells does in a cycle
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_PUSH   = 2'd1,
    OP_ROTATE = 2'd2,
    OP_CLEAR  = 2'd3
  } chain_op_t;

  typedef struct packed {
    logic signed [POS_W-1:0] x;
    logic signed [POS_W-1:0] y;
    logic                    button;
    logic [TIME_W-1:0]       ts;
  } sample_t;

  typedef struct packed {
    logic    valid;
    sample_t smp;
  } entry_t;

endpackage

// ===== design/tdh_if.sv =====
// request and response channel interfaces, valid/ready handshake
// depends on tdh_pkg
interface tdh_req_if;
  import tdh_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [TYPE_W-1:0]         req_type;
  logic [TIME_W-1:0]         now_time;
  logic [DELAY_W-1:0]        delay_amount;
  logic signed [POS_W-1:0]   pos_x;
  logic signed [POS_W-1:0]   pos_y;
  logic                      button_in;

  modport source (output valid, req_type, now_time, delay_amount, pos_x, pos_y, button_in,
                  input ready);
  modport sink   (input valid, req_type, now_time, delay_amount, pos_x, pos_y, button_in,
                  output ready);
endinterface

interface tdh_rsp_if;
  import tdh_pkg::*;
  logic                    valid;
  logic                    ready;
  logic signed [POS_W-1:0] out_x;
  logic signed [POS_W-1:0] out_y;
  logic                    out_button;
  logic [TIME_W-1:0]       out_time;
  logic                    found;
  logic                    gap_warning;

  modport source (output valid, out_x, out_y, out_button, out_time, found, gap_warning,
                  input ready);
  modport sink   (input valid, out_x, out_y, out_button, out_time, found, gap_warning,
                  output ready);
endinterface

// ===== design/tdh_cell.sv =====
// one cell of the history row: holds a single sample and its valid bit
// depends on tdh_pkg
module tdh_cell (
  input  logic               clk,
  input  logic               rst,
  input  tdh_pkg::chain_op_t op,
  input  tdh_pkg::entry_t    push_in,
  input  tdh_pkg::entry_t    rot_in,
  output tdh_pkg::entry_t    q
);
  import tdh_pkg::*;

  logic    valid;
  sample_t smp;

  // valid bit, cleared by reset and by a clear
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      case (op)
        OP_PUSH:   valid <= push_in.valid;
        OP_ROTATE: valid <= rot_in.valid;
        OP_CLEAR:  valid <= 1'b0;
        default:   valid <= valid;
      endcase
    end
  end

  // sample payload, kept across a clear
  always_ff @(posedge clk) begin
    case (op)
      OP_PUSH:   smp <= push_in.smp;
      OP_ROTATE: smp <= rot_in.smp;
      default:   smp <= smp;
    endcase
  end

  assign q = '{valid: valid, smp: smp};

endmodule

// ===== design/tdh_chain.sv =====
// row of DEPTH history cells, newest sample in cell 0
// push shifts toward older cells, rotate walks the row past cell 0
// depends on tdh_pkg and tdh_cell
module tdh_chain (
  input  logic               clk,
  input  logic               rst,
  input  tdh_pkg::chain_op_t op,
  input  tdh_pkg::sample_t   new_smp,
  output tdh_pkg::entry_t    head
);
  import tdh_pkg::*;

  entry_t cell_q [DEPTH];

  // cells linked both ways: push from the newer side, rotate from the older side
  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    entry_t push_in;
    entry_t rot_in;

    if (k == 0) begin : g_first
      assign push_in = '{valid: 1'b1, smp: new_smp};
    end else begin : g_mid
      assign push_in = cell_q[k-1];
    end

    if (k == DEPTH - 1) begin : g_last
      assign rot_in = cell_q[0];
    end else begin : g_inner
      assign rot_in = cell_q[k+1];
    end

    tdh_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .op      (op),
      .push_in (push_in),
      .rot_in  (rot_in),
      .q       (cell_q[k])
    );
  end

  assign head = cell_q[0];

endmodule

// ===== design/timestamped_delay_history_core.sv =====
// Timestamped delay history: pointer samples kept in a row of cells,
// newest first, with a delayed lookup.
//
// Channels: req (sink) carries one request word: record, query or clear.
// rsp (source) carries one word per query; record, clear and the unused
// code give none. cfg_wr_en/cfg_wr_data write gap_limit (reset 60).
// Record, clear and the unused code leave the sequencer idle, so req.ready
// stays high. A query rotates the whole row once past cell 0, comparing
// the sample there against the target time at each step, then forms the
// result; req.ready is low from acceptance until the result is loaded, so
// no new request is taken while a query is in progress.
// The response sits in an output register: while the receiver stalls,
// new requests are still taken; a finished query waits in its last state
// until the output register is free.
// Reset (synchronous) invalidates every cell, empties the output register
// and sets gap_limit to 60; no clearing pass is needed.
// depends on tdh_pkg, tdh_if, tdh_chain and the defines header
`include "timestamped_delay_history_core_defines.svh"

module timestamped_delay_history_core (
  input  logic                      clk,
  input  logic                      rst,
  tdh_req_if.sink                   req,
  tdh_rsp_if.source                 rsp,
  input  logic                      cfg_wr_en,
  input  logic [tdh_pkg::GAP_W-1:0] cfg_wr_data
);
  import tdh_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_SCAN = 3'b010,
    S_DONE = 3'b100
  } state_t;

  state_t            state;
  state_t            state_next;
  logic [GAP_W-1:0]  gap_limit;
  logic [TIME_W-1:0] target;
  logic              neg;
  logic [IDX_W-1:0]  cnt;
  logic              hit;
  entry_t            sel;
  chain_op_t         op;
  entry_t            head;
  sample_t           new_smp;
  logic              req_fire;
  logic              is_query;
  logic [TIME_W:0]   diff;
  logic              hit_now;
  logic              scan_last;
  logic              out_free;
  logic [TIME_W-1:0] gap;
  logic              warn;
  sample_t           res_smp;
  logic              out_valid;
  sample_t           out_smp;
  logic              out_found;
  logic              out_warn;

  // configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      gap_limit <= GAP_RESET;
    end else if (cfg_wr_en) begin
      gap_limit <= cfg_wr_data;
    end
  end

  // request handshake and decode
  assign req.ready = (state == S_IDLE);
  assign req_fire  = req.valid && req.ready;
  assign is_query  = (req.req_type == REQ_QUERY);
  assign new_smp   = '{x: req.pos_x, y: req.pos_y, button: req.button_in, ts: req.now_time};

  // target time with borrow: top bit set means the target is negative
  assign diff = {1'b0, req.now_time} - {{(TIME_W + 1 - DELAY_W){1'b0}}, req.delay_amount};

  // operation of the cell row this cycle
  always_comb begin
    op = OP_HOLD;
    if (state == S_SCAN) begin
      op = OP_ROTATE;
    end else if (req_fire) begin
      case (req.req_type)
        REQ_RECORD: op = OP_PUSH;
        REQ_CLEAR:  op = OP_CLEAR;
        default:    op = OP_HOLD;
      endcase
    end
  end

  tdh_chain u_chain (
    .clk     (clk),
    .rst     (rst),
    .op      (op),
    .new_smp (new_smp),
    .head    (head)
  );

  // compare against the sample passing cell 0
  assign hit_now   = head.valid && !neg && (head.smp.ts <= target);
  assign scan_last = (cnt == IDX_W'(DEPTH - 1));
  assign out_free  = !out_valid || rsp.ready;

  // result forming
  assign gap     = target - sel.smp.ts;
  assign warn    = hit && (gap > {{(TIME_W - GAP_W){1'b0}}, gap_limit});
  assign res_smp = (hit || sel.valid) ? sel.smp : '0;

  // sequencer next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (req_fire && is_query) state_next = S_SCAN;
      S_SCAN:  if (scan_last) state_next = S_DONE;
      S_DONE:  if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // scan datapath: newest sample at step zero, first hit kept afterwards
  always_ff @(posedge clk) begin
    if (req_fire && is_query) begin
      target <= diff[TIME_W-1:0];
      neg    <= diff[TIME_W];
      cnt    <= '0;
      hit    <= 1'b0;
    end else if (state == S_SCAN) begin
      cnt <= cnt + IDX_W'(1);
      if ((cnt == '0) || (!hit && hit_now)) begin
        sel <= head;
      end
      if (!hit && hit_now) begin
        hit <= 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      out_smp   <= res_smp;
      out_found <= hit;
      out_warn  <= warn;
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.out_x       = out_smp.x;
  assign rsp.out_y       = out_smp.y;
  assign rsp.out_button  = out_smp.button;
  assign rsp.out_time    = out_smp.ts;
  assign rsp.found       = out_found;
  assign rsp.gap_warning = out_warn;

  // checks
  `TDH_ASSERT_NOW(a_state_onehot, 1'b1, $onehot(state))
  `TDH_ASSERT_NEXT(a_scan_ends, (state == S_SCAN) && scan_last, state == S_DONE)
  `TDH_ASSERT_NEXT(a_result_loads, (state == S_DONE) && out_free, rsp.valid && (state == S_IDLE))
  `TDH_ASSERT_NOW(a_warn_needs_found, rsp.valid && rsp.gap_warning, rsp.found)

endmodule
